FILE: hdl/vmix_pkg.sv
package vmix_pkg;

  localparam int unsigned LaneW = 16;
  localparam int unsigned ProdW = 31;
  localparam int unsigned QuotW = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LaneW-1:0] LaneMax = 16'h7FFF;
  localparam logic [LaneW-1:0] LaneMin = 16'h8000;
  localparam logic [LaneW-1:0] UnityGain = 16'h8000;
  localparam logic [LaneW-1:0] PanFull = 16'd32767;

  localparam logic [CfgIdxW-1:0] RegStereoOut = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEightBit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegUnsigned = 2'd2;

  localparam logic [1:0] DupNone = 2'd0;
  localparam logic [1:0] DupLane0 = 2'd1;
  localparam logic [1:0] DupLane1 = 2'd2;

  typedef struct packed {
    logic capture;
    logic gain_en;
    logic scale_en;
    logic div_en;
    logic acc_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

  // floor(p / 32767) for p <= 2^30, via shift and at most two corrections
  function automatic logic [QuotW-1:0] div_lane_max(input logic [ProdW-1:0] p);
    logic [QuotW-1:0] q0;
    logic [QuotW-1:0] rem;
    logic [QuotW-1:0] q;
    q0 = {1'b0, p[ProdW-1:15]};
    rem = {2'b00, p[14:0]} + q0;
    if (rem >= 17'd65534) begin
      q = q0 + 17'd2;
    end else if (rem >= 17'd32767) begin
      q = q0 + 17'd1;
    end else begin
      q = q0;
    end
    return q;
  endfunction

  // apply sign to magnitude and saturate to a signed lane
  function automatic logic [LaneW-1:0] signed_sat(input logic neg, input logic [QuotW-1:0] q);
    logic [LaneW-1:0] r;
    if (neg) begin
      if (q >= 17'd32768) begin
        r = LaneMin;
      end else begin
        r = ~q[LaneW-1:0] + 16'd1;
      end
    end else begin
      if (q >= 17'd32767) begin
        r = LaneMax;
      end else begin
        r = q[LaneW-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [LaneW-1:0] add_sat(input logic [LaneW-1:0] a,
                                              input logic [LaneW-1:0] b);
    logic [LaneW:0] s;
    logic [LaneW-1:0] r;
    s = {a[LaneW-1], a} + {b[LaneW-1], b};
    if (s[LaneW] != s[LaneW-1]) begin
      r = s[LaneW] ? LaneMin : LaneMax;
    end else begin
      r = s[LaneW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/vmix_ctrl.sv
module vmix_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vmix_pkg::dp_cmd_t cmd,
  input  vmix_pkg::dp_sts_t sts
);
  import vmix_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_SCALE,
    S_DIV,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_space;

  assign out_space = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.gain_en = (state_r == S_GAIN);
    cmd.scale_en = (state_r == S_SCALE);
    cmd.div_en = (state_r == S_DIV);
    cmd.acc_en = (state_r == S_ACC);
    cmd.out_load = (state_r == S_EMIT) && out_space;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_GAIN;
          end
        end
        S_GAIN:  state_r <= S_SCALE;
        S_SCALE: state_r <= S_DIV;
        S_DIV:   state_r <= S_ACC;
        S_ACC:   state_r <= sts.last ? S_EMIT : S_IDLE;
        S_EMIT: begin
          if (out_space) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_load_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result not shown after load");

  a_acc_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> $past(cmd.div_en))
    else $error("accumulate without divide step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_GAIN))
    else $error("accepted transaction not started");

endmodule

FILE: hdl/vmix_dp.sv
module vmix_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  vmix_pkg::dp_cmd_t cmd,
  output vmix_pkg::dp_sts_t sts,
  input  logic              cfg_stereo,
  input  logic              cfg_eight,
  input  logic              cfg_unsigned,
  input  logic [15:0]       in_sample_low_lane,
  input  logic [15:0]       in_sample_high_lane,
  input  logic [15:0]       in_level,
  input  logic [15:0]       in_pan,
  input  logic [1:0]        in_dup_mode,
  input  logic              in_first_voice,
  input  logic              in_last_voice,
  output logic [15:0]       mixed_low_lane,
  output logic [15:0]       mixed_high_lane
);
  import vmix_pkg::*;

  logic [LaneW-1:0] raw [2];
  logic [LaneW-1:0] lane_in [2];
  logic [LaneW-1:0] fac [2];
  logic [LaneW-1:0] level_c;
  logic [LaneW-1:0] pan_c;
  logic [2*LaneW-1:0] gain_prod [2];
  logic [2*LaneW-1:0] scale_prod [2];
  logic [LaneW-1:0] acc_lane [2];
  logic [LaneW-1:0] acc_new [2];
  logic [LaneW-1:0] out_lane [2];

  logic             neg_r [2];
  logic [LaneW-1:0] mag_r [2];
  logic [LaneW-1:0] fac_r [2];
  logic [LaneW-1:0] level_r;
  logic [LaneW-1:0] gain_r [2];
  logic [ProdW-1:0] prod_r [2];
  logic [LaneW-1:0] scaled_r [2];
  logic             first_r;
  logic             last_r;
  logic [LaneW-1:0] acc_r [2];
  logic [LaneW-1:0] mixed_r [2];

  always_comb begin
    raw[0] = cfg_eight ? {in_sample_low_lane[7:0], 8'h00} : in_sample_low_lane;
    raw[1] = cfg_eight ? {in_sample_high_lane[7:0], 8'h00} : in_sample_high_lane;
    for (int k = 0; k < 2; k++) begin
      raw[k] = raw[k] ^ {cfg_unsigned, 15'b0};
    end
    priority if (in_dup_mode == DupLane0) begin
      lane_in[0] = raw[0];
      lane_in[1] = raw[0];
    end else if (in_dup_mode == DupLane1) begin
      lane_in[0] = raw[1];
      lane_in[1] = raw[1];
    end else begin
      lane_in[0] = raw[0];
      lane_in[1] = raw[1];
    end
    level_c = (in_level > UnityGain) ? UnityGain : in_level;
    pan_c = (in_pan == LaneMin) ? (~PanFull + 16'd1) : in_pan;
    if (pan_c[LaneW-1]) begin
      fac[0] = PanFull + pan_c;
      fac[1] = UnityGain;
    end else begin
      fac[0] = UnityGain;
      fac[1] = PanFull - pan_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      gain_prod[k] = {16'b0, fac_r[k]} * {16'b0, level_r};
      scale_prod[k] = {16'b0, mag_r[k]} * {16'b0, gain_r[k]};
      acc_lane[k] = cfg_eight ? {acc_r[k][15:8], 8'h00} : acc_r[k];
      acc_new[k] = first_r ? scaled_r[k] : add_sat(scaled_r[k], acc_lane[k]);
      if (cfg_eight) begin
        acc_new[k] = {acc_new[k][15:8], 8'h00};
        out_lane[k] = {8'h00, acc_r[k][15:8] ^ {cfg_unsigned, 7'b0}};
      end else begin
        out_lane[k] = acc_r[k] ^ {cfg_unsigned, 15'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (cmd.capture) begin
        neg_r[k] <= lane_in[k][LaneW-1];
        mag_r[k] <= lane_in[k][LaneW-1] ? (~lane_in[k] + 16'd1) : lane_in[k];
        fac_r[k] <= fac[k];
      end
      if (cmd.gain_en) begin
        gain_r[k] <= cfg_stereo ? gain_prod[k][30:15] : level_r;
      end
      if (cmd.scale_en) begin
        prod_r[k] <= scale_prod[k][ProdW-1:0];
      end
      if (cmd.div_en) begin
        scaled_r[k] <= signed_sat(neg_r[k], div_lane_max(prod_r[k]));
      end
      if (cmd.out_load) begin
        mixed_r[k] <= out_lane[k];
      end
    end
    if (cmd.capture) begin
      level_r <= level_c;
      first_r <= in_first_voice;
      last_r <= in_last_voice;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end else if (cmd.acc_en) begin
      acc_r[0] <= acc_new[0];
      acc_r[1] <= acc_new[1];
    end
  end

  assign sts.last = last_r;
  assign mixed_low_lane = mixed_r[0];
  assign mixed_high_lane = mixed_r[1];

  a_eight_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_en && cfg_eight) |=> (acc_r[0][7:0] == 8'h00 && acc_r[1][7:0] == 8'h00))
    else $error("low byte kept in 8-bit mode");

  a_first_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_en && first_r && !cfg_eight) |=> (acc_r[0] == $past(scaled_r[0])))
    else $error("first voice did not load accumulator");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.gain_en) |-> (gain_r[0] <= UnityGain && gain_r[1] <= UnityGain))
    else $error("loudness above unity");

endmodule

FILE: hdl/voice_mixer_gain_pan_saturate.sv
// a last voice raises out_valid once the emit state has loaded the output register; emit waits for output space
// a new voice is accepted only in idle, once the previous one is through; each voice walks
// capture, loudness multiply, sample multiply, divide by 32767, accumulate
// output register frees the input side while a result waits
// reset (rst_n low, synchronous): accumulator cleared, stereo_out 1,
// eight_bit_mode 0, unsigned_samples 0, no result pending
module voice_mixer_gain_pan_saturate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vmix_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [0:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  in_sample_low_lane,
  input  logic [15:0]                  in_sample_high_lane,
  input  logic [15:0]                  in_level,
  input  logic signed [15:0]           in_pan,
  input  logic [1:0]                   in_dup_mode,
  input  logic                         in_first_voice,
  input  logic                         in_last_voice,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_mixed_low_lane,
  output logic [15:0]                  out_mixed_high_lane
);
  import vmix_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    stereo_out_r;
  logic    eight_bit_mode_r;
  logic    unsigned_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_out_r <= 1'b1;
      eight_bit_mode_r <= 1'b0;
      unsigned_samples_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegStereoOut: stereo_out_r <= cfg_data[0];
        RegEightBit:  eight_bit_mode_r <= cfg_data[0];
        RegUnsigned:  unsigned_samples_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vmix_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vmix_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_stereo          (stereo_out_r),
    .cfg_eight           (eight_bit_mode_r),
    .cfg_unsigned        (unsigned_samples_r),
    .in_sample_low_lane  (in_sample_low_lane),
    .in_sample_high_lane (in_sample_high_lane),
    .in_level            (in_level),
    .in_pan              (in_pan),
    .in_dup_mode         (in_dup_mode),
    .in_first_voice      (in_first_voice),
    .in_last_voice       (in_last_voice),
    .mixed_low_lane      (out_mixed_low_lane),
    .mixed_high_lane     (out_mixed_high_lane)
  );

endmodule
